// ===== rtl/core/quad_downmix_saturating_mixer_top_defines.svh =====
// Assertion macros shared by the downmix mixer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUAD_DOWNMIX_SATURATING_MIXER_TOP_DEFINES_SVH
`define QUAD_DOWNMIX_SATURATING_MIXER_TOP_DEFINES_SVH

// Plain condition, checked every cycle out of reset.
`define QDM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define QDM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define QDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qdm_pkg.sv =====
// Shared types, codes and arithmetic helpers for the quad downmix mixer.
// No dependencies; used by the interfaces and all RTL modules.
package qdm_pkg;

    localparam int CH_W    = 32;
    localparam int GAIN_W  = 16;
    localparam int OUT_W   = 16;
    localparam int SUM_W   = CH_W + 2;              // four-way sum
    localparam int PROD_W  = SUM_W + GAIN_W + 1;    // sum x unsigned gain
    localparam int SHIFT_W = 5;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 3);   // holds count plus in-flight

    localparam logic signed [OUT_W-1:0] S16_MIN = -16'sd32768;
    localparam logic signed [OUT_W-1:0] S16_MAX = 16'sd32767;

    // config register indexes
    typedef enum logic [1:0] {
        REG_OUTPUT_MODE = 2'd0,
        REG_GAIN_MIX0   = 2'd1,
        REG_GAIN_MIX1   = 2'd2,
        REG_GAIN_MIX2   = 2'd3
    } reg_idx_t;

    // output_mode codes; anything else is stereo
    localparam logic [1:0] MODE_MONO     = 2'd0;
    localparam logic [1:0] MODE_STEREO   = 2'd1;
    localparam logic [1:0] MODE_SURROUND = 2'd2;

    // mix path codes
    localparam logic [1:0] SEL_MIX0 = 2'd0;
    localparam logic [1:0] SEL_MIX1 = 2'd1;
    localparam logic [1:0] SEL_MIX2 = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // scaled item passed from the front end to the accumulator
    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    fin;
    } item_t;

    // queue status seen by the front end
    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    // product / 2^shift, truncated toward zero, saturated to s16
    function automatic logic signed [OUT_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] prod,
        input logic [SHIFT_W-1:0]       shift
    );
        logic signed [PROD_W-1:0] mask;
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] q;
        mask = (PROD_W'(1) <<< shift) - PROD_W'(1);
        bias = prod[PROD_W-1] ? mask : '0;
        q    = (prod + bias) >>> shift;
        if (q < S16_MIN)
            return S16_MIN;
        else if (q > S16_MAX)
            return S16_MAX;
        else
            return q[OUT_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_add16(
        input logic signed [OUT_W-1:0] a,
        input logic signed [OUT_W-1:0] b
    );
        logic signed [OUT_W:0] s;
        s = {a[OUT_W-1], a} + {b[OUT_W-1], b};
        if (s[OUT_W] != s[OUT_W-1])
            return s[OUT_W] ? S16_MIN : S16_MAX;
        else
            return s[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/qdm_in_if.sv =====
// Input channel: one quad sample of one mix path per beat.
// Depends on qdm_pkg for field widths.
interface qdm_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mix_select;
    logic signed [qdm_pkg::CH_W-1:0] ch0;
    logic signed [qdm_pkg::CH_W-1:0] ch1;
    logic signed [qdm_pkg::CH_W-1:0] ch2;
    logic signed [qdm_pkg::CH_W-1:0] ch3;
    logic                            final_mix;

    modport source (output valid, mix_select, ch0, ch1, ch2, ch3, final_mix, input ready);
    modport sink   (input valid, mix_select, ch0, ch1, ch2, ch3, final_mix, output ready);
endinterface

// ===== rtl/core/qdm_out_if.sv =====
// Output channel: one stereo mixed sample per beat.
// Depends on qdm_pkg for field widths.
interface qdm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [qdm_pkg::OUT_W-1:0] out_left;
    logic signed [qdm_pkg::OUT_W-1:0] out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink   (input valid, out_left, out_right, output ready);
endinterface

// ===== rtl/core/qdm_front.sv =====
// Front end: config registers, beat acceptance, downmix sums, gain multiply
// and scaling. Depends on qdm_pkg, qdm_in_if and the assertion macros.
`include "quad_downmix_saturating_mixer_top_defines.svh"

module qdm_front #(
    parameter int GAIN_FRAC_BITS = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    qdm_in_if.sink                     samples,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [qdm_pkg::GAIN_W-1:0] cfg_wdata,
    input  qdm_pkg::q_stat_t           q_stat,
    output logic                       push,
    output qdm_pkg::item_t             push_item
);

    localparam int SUM_W   = qdm_pkg::SUM_W;
    localparam int PROD_W  = qdm_pkg::PROD_W;
    localparam int GAIN_W  = qdm_pkg::GAIN_W;
    localparam int Q_CNT_W = qdm_pkg::Q_CNT_W;

    logic [1:0]        mode_reg;
    logic [GAIN_W-1:0] gain0_reg;
    logic [GAIN_W-1:0] gain1_reg;
    logic [GAIN_W-1:0] gain2_reg;

    logic                     s1_valid_reg;
    logic signed [SUM_W-1:0]  s1_left_reg;
    logic signed [SUM_W-1:0]  s1_right_reg;
    logic [GAIN_W-1:0]        s1_gain_reg;
    logic                     s1_mono_reg;
    logic                     s1_fin_reg;

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_left_reg;
    logic signed [PROD_W-1:0] s2_right_reg;
    logic                     s2_mono_reg;
    logic                     s2_fin_reg;

    logic                     accept;
    logic [Q_CNT_W-1:0]       reserved;
    logic [GAIN_W-1:0]        gain_sel;
    logic                     mono;
    logic signed [SUM_W-1:0]  c0, c1, c2, c3;
    logic signed [SUM_W-1:0]  sum_left;
    logic signed [SUM_W-1:0]  sum_right;
    logic [qdm_pkg::SHIFT_W-1:0] shift;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= qdm_pkg::MODE_STEREO;
            gain0_reg <= qdm_pkg::GAIN_RESET;
            gain1_reg <= qdm_pkg::GAIN_RESET;
            gain2_reg <= qdm_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (qdm_pkg::reg_idx_t'(cfg_index))
                qdm_pkg::REG_OUTPUT_MODE: mode_reg  <= cfg_wdata[1:0];
                qdm_pkg::REG_GAIN_MIX0:   gain0_reg <= cfg_wdata;
                qdm_pkg::REG_GAIN_MIX1:   gain1_reg <= cfg_wdata;
                qdm_pkg::REG_GAIN_MIX2:   gain2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // every beat in flight already owns a queue slot
    assign reserved      = q_stat.count + Q_CNT_W'(s1_valid_reg) + Q_CNT_W'(s2_valid_reg);
    assign samples.ready = (reserved < Q_CNT_W'(qdm_pkg::Q_DEPTH));
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        unique case (samples.mix_select)
            qdm_pkg::SEL_MIX0: gain_sel = gain0_reg;
            qdm_pkg::SEL_MIX1: gain_sel = gain1_reg;
            qdm_pkg::SEL_MIX2: gain_sel = gain2_reg;
            default:           gain_sel = '0;
        endcase
    end

    assign mono = (mode_reg == qdm_pkg::MODE_MONO);
    assign c0   = SUM_W'(samples.ch0);
    assign c1   = SUM_W'(samples.ch1);
    assign c2   = SUM_W'(samples.ch2);
    assign c3   = SUM_W'(samples.ch3);

    always_comb
    begin
        if (mono)
        begin
            sum_left  = c0 + c1 + c2 + c3;
            sum_right = sum_left;
        end
        else
        begin
            sum_left  = c0 + c2;
            sum_right = c1 + c3;
        end
    end

    // stage 1: sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_left_reg  <= sum_left;
            s1_right_reg <= sum_right;
            s1_gain_reg  <= gain_sel;
            s1_mono_reg  <= mono;
            s1_fin_reg   <= samples.final_mix;
        end
    end

    // stage 2: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_left_reg  <= PROD_W'(s1_left_reg) * PROD_W'($signed({1'b0, s1_gain_reg}));
            s2_right_reg <= PROD_W'(s1_right_reg) * PROD_W'($signed({1'b0, s1_gain_reg}));
            s2_mono_reg  <= s1_mono_reg;
            s2_fin_reg   <= s1_fin_reg;
        end
    end

    // mono halves on top of the gain scaling
    assign shift = qdm_pkg::SHIFT_W'(GAIN_FRAC_BITS) + qdm_pkg::SHIFT_W'(s2_mono_reg);

    assign push            = s2_valid_reg;
    assign push_item.left  = qdm_pkg::scale_sat(s2_left_reg, shift);
    assign push_item.right = qdm_pkg::scale_sat(s2_right_reg, shift);
    assign push_item.fin   = s2_fin_reg;

    `QDM_ASSERT(a_slots_reserved, reserved <= Q_CNT_W'(qdm_pkg::Q_DEPTH), "queue overbooked")
    `QDM_ASSERT_NEXT(a_s1_follows, accept, s1_valid_reg, "accepted beat lost in stage 1")
    `QDM_ASSERT_IMPL(a_mono_equal, s2_valid_reg && s2_mono_reg,
        s2_left_reg == s2_right_reg, "mono sides differ")

endmodule

// ===== rtl/core/qdm_queue.sv =====
// Short register queue between the front end and the accumulator.
// Depends on qdm_pkg and the assertion macros.
`include "quad_downmix_saturating_mixer_top_defines.svh"

module qdm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qdm_pkg::item_t   push_item,
    input  logic             pop,
    output logic             not_empty,
    output qdm_pkg::item_t   head,
    output qdm_pkg::q_stat_t q_stat
);

    localparam int DEPTH   = qdm_pkg::Q_DEPTH;
    localparam int PTR_W   = qdm_pkg::Q_PTR_W;
    localparam int CNT_W   = qdm_pkg::Q_CNT_W;

    qdm_pkg::item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    assign not_empty    = (count_reg != '0);
    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.count = count_reg;

    `QDM_ASSERT_IMPL(a_no_overflow, count_reg == CNT_W'(DEPTH), !push || pop, "queue overflow")
    `QDM_ASSERT_IMPL(a_no_underflow, pop, not_empty, "queue underflow")
    `QDM_ASSERT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0],
        "queue pointers and count disagree")

endmodule

// ===== rtl/core/qdm_back.sv =====
// Back end: saturating left/right accumulator and the output register.
// Depends on qdm_pkg, qdm_out_if and the assertion macros.
`include "quad_downmix_saturating_mixer_top_defines.svh"

module qdm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  qdm_pkg::item_t head,
    output logic           pop,
    qdm_out_if.source      mixed
);

    localparam int OUT_W = qdm_pkg::OUT_W;

    logic signed [OUT_W-1:0] acc_left_reg;
    logic signed [OUT_W-1:0] acc_right_reg;
    logic signed [OUT_W-1:0] sum_left;
    logic signed [OUT_W-1:0] sum_right;
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] out_left_reg;
    logic signed [OUT_W-1:0] out_right_reg;
    logic                    out_free;
    logic                    emit;

    // a final beat needs the output register free (or draining this cycle)
    assign out_free = !out_valid_reg || mixed.ready;
    assign pop      = not_empty && (!head.fin || out_free);
    assign emit     = pop && head.fin;

    assign sum_left  = qdm_pkg::sat_add16(acc_left_reg, head.left);
    assign sum_right = qdm_pkg::sat_add16(acc_right_reg, head.right);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_left_reg  <= '0;
            acc_right_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                acc_left_reg  <= '0;
                acc_right_reg <= '0;
            end
            else if (pop)
            begin
                acc_left_reg  <= sum_left;
                acc_right_reg <= sum_right;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (mixed.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_left_reg  <= sum_left;
            out_right_reg <= sum_right;
        end
    end

    assign mixed.valid     = out_valid_reg;
    assign mixed.out_left  = out_left_reg;
    assign mixed.out_right = out_right_reg;

    `QDM_ASSERT_NEXT(a_clear_after_emit, emit,
        acc_left_reg == '0 && acc_right_reg == '0, "accumulator not cleared")
    `QDM_ASSERT_IMPL(a_no_emit_over_pending, emit, out_free, "output overwritten")
    `QDM_ASSERT_NEXT(a_emit_shows, emit, out_valid_reg, "emitted beat not presented")

endmodule

// ===== rtl/core/quad_downmix_saturating_mixer_top.sv =====
// Quad-to-stereo downmix mixer: one item per clock at full rate. A beat
// passes two register stages in the front end (sums, then gain product;
// scaling and saturation sit on the queue input) and one in the queue, and
// the accumulator takes it from the queue head, so a result is loaded into
// the output register when its final beat is popped there with the output
// register free or draining. Sustained rate is one beat per cycle, set by
// the four-entry queue: input ready drops only when queued plus in-flight
// beats fill it, which happens only while the output side stalls. The
// output register holds one finished sample while new beats keep entering.
// Depends on qdm_pkg, qdm_in_if, qdm_out_if, qdm_front, qdm_queue, qdm_back.
module quad_downmix_saturating_mixer_top #(
    parameter int GAIN_FRAC_BITS = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    qdm_in_if.sink                     samples,
    qdm_out_if.source                  mixed,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [qdm_pkg::GAIN_W-1:0] cfg_wdata
);

    qdm_pkg::q_stat_t q_stat;
    qdm_pkg::item_t   push_item;
    qdm_pkg::item_t   head;
    logic             push;
    logic             pop;
    logic             not_empty;

    qdm_front #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    qdm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .q_stat    (q_stat)
    );

    qdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .mixed     (mixed)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for quad_downmix_saturating_mixer_top: directed table, then random
// mix-path sequences under random valid/ready idling, checked beat by beat by a local predictor.
// Depends on qdm_pkg, qdm_in_if, qdm_out_if and the RTL of the mixer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_W        = qdm_pkg::CH_W;
    localparam int OUT_W       = qdm_pkg::OUT_W;
    localparam int GAIN_W      = qdm_pkg::GAIN_W;
    localparam int FRAC        = 14;
    localparam int SETTLE      = 10;     // front end plus accumulator, with margin
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 125;
    localparam logic [1:0] SEL_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]              sel;
        logic signed [CH_W-1:0]  ch0;
        logic signed [CH_W-1:0]  ch1;
        logic signed [CH_W-1:0]  ch2;
        logic signed [CH_W-1:0]  ch3;
        logic                    fin;
    } mix_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } mix_out_t;

    typedef struct {
        bit                  is_cfg;
        qdm_pkg::reg_idx_t   idx;
        logic [15:0]         val;
        mix_beat_t           beat;
        bit                  typed;
        mix_out_t            want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [GAIN_W-1:0] cfg_wdata;

    qdm_in_if  samples_if ();
    qdm_out_if mixed_if ();

    quad_downmix_saturating_mixer_top #(
        .GAIN_FRAC_BITS (FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .mixed     (mixed_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of configuration and accumulator
    logic [1:0]              mode_now;
    logic [GAIN_W-1:0]       gain_now [3];
    logic signed [OUT_W-1:0] acc_l;
    logic signed [OUT_W-1:0] acc_r;

    mix_out_t mix_expect_q [$];
    int errors          = 0;
    int beats_in        = 0;
    int samples_checked = 0;
    int reg_writes      = 0;
    int tx_run          = 0;
    int rx_run          = 0;
    bit tx_calm         = 0;
    bit rx_calm         = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic signed [OUT_W-1:0] clamp16(input longint v);
        if (v < -32768)
            return -16'sd32768;
        if (v > 32767)
            return 16'sd32767;
        return v[OUT_W-1:0];
    endfunction

    // exact product, then divide with truncation toward zero
    function automatic logic signed [OUT_W-1:0] gain_scale(input longint sum,
                                                           input logic [GAIN_W-1:0] g,
                                                           input int shift);
        longint p;
        p = sum * longint'(g);
        return clamp16(p / (longint'(1) << shift));
    endfunction

    task automatic mix_predict(input mix_beat_t b, output bit emit, output mix_out_t res);
        logic [GAIN_W-1:0]       g;
        logic signed [OUT_W-1:0] l;
        logic signed [OUT_W-1:0] r;
        longint                  c0, c1, c2, c3;
        c0 = longint'($signed(b.ch0));
        c1 = longint'($signed(b.ch1));
        c2 = longint'($signed(b.ch2));
        c3 = longint'($signed(b.ch3));
        case (b.sel)
            qdm_pkg::SEL_MIX0: g = gain_now[0];
            qdm_pkg::SEL_MIX1: g = gain_now[1];
            qdm_pkg::SEL_MIX2: g = gain_now[2];
            default:           g = '0;
        endcase
        if (mode_now == qdm_pkg::MODE_MONO)
        begin
            l = gain_scale(c0 + c1 + c2 + c3, g, FRAC + 1);
            r = l;
        end
        else
        begin
            l = gain_scale(c0 + c2, g, FRAC);
            r = gain_scale(c1 + c3, g, FRAC);
        end
        acc_l = clamp16(longint'(acc_l) + longint'(l));
        acc_r = clamp16(longint'(acc_r) + longint'(r));
        emit = b.fin;
        res.left = acc_l;
        res.right = acc_r;
        if (b.fin)
        begin
            acc_l = '0;
            acc_r = '0;
        end
    endtask

    // runs of 4..40 draws, each run calm (no idling) with chance 1/4, else with random waits
    function automatic int draw_wait(inout int run, inout bit calm);
        if (run <= 0)
        begin
            run = $urandom_range(4, 40);
            calm = ($urandom_range(0, 3) == 0);
        end
        run--;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic signed [CH_W-1:0] rand_ch();
        int m;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7fff_ffff;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2:    return $urandom();
            default:
            begin
                m = $urandom_range(0, 1 << $urandom_range(2, 16));
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'hffff;
            2:       return qdm_pkg::GAIN_RESET;
            default: return GAIN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic dir_row_t beat_row(input logic [1:0] s,
                                          input logic signed [CH_W-1:0] c0, c1, c2, c3,
                                          input bit f, input bit typed = 0,
                                          input int wl = 0, input int wr = 0);
        dir_row_t r;
        r.is_cfg = 0;
        r.idx = qdm_pkg::REG_OUTPUT_MODE;
        r.val = '0;
        r.beat.sel = s;
        r.beat.ch0 = c0;
        r.beat.ch1 = c1;
        r.beat.ch2 = c2;
        r.beat.ch3 = c3;
        r.beat.fin = f;
        r.typed = typed;
        r.want.left = wl[OUT_W-1:0];
        r.want.right = wr[OUT_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input qdm_pkg::reg_idx_t i, input logic [15:0] v);
        dir_row_t r;
        r.is_cfg = 1;
        r.idx = i;
        r.val = v;
        r.beat = '0;
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    task automatic send_beat(input mix_beat_t b, input bit typed, input mix_out_t want);
        int       gap;
        bit       emit;
        mix_out_t res;
        gap = draw_wait(tx_run, tx_calm);
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid      <= 1'b1;
        samples_if.mix_select <= b.sel;
        samples_if.ch0        <= b.ch0;
        samples_if.ch1        <= b.ch1;
        samples_if.ch2        <= b.ch2;
        samples_if.ch3        <= b.ch3;
        samples_if.final_mix  <= b.fin;
        do
            @(posedge clk);
        while (!samples_if.ready);
        beats_in++;
        mix_predict(b, emit, res);
        if (emit)
            mix_expect_q.push_back(typed ? want : res);
    endtask

    // hold off the sender until every expected sample is out; settle covers
    // beats with no final mark still in the pipe
    task automatic wait_idle(input bit settle);
        samples_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (mix_expect_q.size() != 0);
        if (settle)
            repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input qdm_pkg::reg_idx_t i, input logic [GAIN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= i;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (i)
            qdm_pkg::REG_OUTPUT_MODE: mode_now = v[1:0];
            qdm_pkg::REG_GAIN_MIX0:   gain_now[0] = v;
            qdm_pkg::REG_GAIN_MIX1:   gain_now[1] = v;
            qdm_pkg::REG_GAIN_MIX2:   gain_now[2] = v;
        endcase
        reg_writes++;
    endtask

    // mostly well-formed sample times (paths 0,1,2, final on the last), some noise
    task automatic send_random(input int n, input bit pause_mid);
        int        sent;
        int        k;
        bit        paused;
        mix_beat_t b;
        mix_out_t  none;
        sent = 0;
        paused = 0;
        none = '0;
        while (sent < n)
        begin
            if (pause_mid && !paused && sent >= n / 2)
            begin
                wait_idle(0);
                paused = 1;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                for (int p = 0; p < 3; p++)
                begin
                    b.sel = p[1:0];
                    b.ch0 = rand_ch();
                    b.ch1 = rand_ch();
                    b.ch2 = rand_ch();
                    b.ch3 = rand_ch();
                    b.fin = (p == 2);
                    send_beat(b, 0, none);
                end
                sent += 3;
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    b.sel = 2'($urandom_range(0, 3));
                    b.ch0 = rand_ch();
                    b.ch1 = rand_ch();
                    b.ch2 = rand_ch();
                    b.ch3 = rand_ch();
                    b.fin = 1'($urandom_range(0, 1));
                    send_beat(b, 0, none);
                end
                sent += k;
            end
        end
    endtask

    initial
    begin : sink_side
        int stall;
        mixed_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_run, rx_calm);
            if (stall > 0)
            begin
                mixed_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            mixed_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(mixed_if.valid && mixed_if.ready));
        end
    end

    always @(posedge clk)
    begin : out_check
        mix_out_t w;
        if (rst_n && mixed_if.valid === 1'b1 && mixed_if.ready === 1'b1)
        begin
            if (mix_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected mixed beat, expected none, got L=%0d R=%0d",
                         $time, mixed_if.out_left, mixed_if.out_right);
            end
            else
            begin
                w = mix_expect_q.pop_front();
                samples_checked++;
                if (mixed_if.out_left !== w.left)
                begin
                    errors++;
                    $display("%0t: out_left mismatch, expected %0d, got %0d",
                             $time, w.left, mixed_if.out_left);
                end
                if (mixed_if.out_right !== w.right)
                begin
                    errors++;
                    $display("%0t: out_right mismatch, expected %0d, got %0d",
                             $time, w.right, mixed_if.out_right);
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t          plan [$];
        logic [1:0]        m;
        logic [GAIN_W-1:0] g [3];

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= qdm_pkg::REG_OUTPUT_MODE;
        cfg_wdata             <= '0;
        samples_if.valid      <= 1'b0;
        samples_if.mix_select <= qdm_pkg::SEL_MIX0;
        samples_if.ch0        <= '0;
        samples_if.ch1        <= '0;
        samples_if.ch2        <= '0;
        samples_if.ch3        <= '0;
        samples_if.final_mix  <= 1'b0;
        mode_now = qdm_pkg::MODE_STEREO;
        gain_now = '{qdm_pkg::GAIN_RESET, qdm_pkg::GAIN_RESET, qdm_pkg::GAIN_RESET};
        acc_l = '0;
        acc_r = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: stereo, unity gains
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 0, 0, 0, 0, 1, 1, 0, 0));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 100, -200, 50, 0, 1, 1, 150, -200));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX1, 32'sh7fff_ffff, 32'sh8000_0000,
                                32'sh7fff_ffff, 32'sh8000_0000, 1, 1, 32767, -32768));
        // unused path adds nothing, final still emits
        plan.push_back(beat_row(SEL_UNUSED, 1000, 1000, 1000, 1000, 1, 1, 0, 0));
        // accumulator clips, then backs off
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 20000, 0, 0, -20000, 0));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX1, 20000, 0, 0, -20000, 0));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX2, -5, 0, 0, 5, 1, 1, 32762, -32763));
        plan.push_back(cfg_row(qdm_pkg::REG_GAIN_MIX0, 16'hffff));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 1, -1, 0, 0, 1, 1, 3, -3));
        plan.push_back(cfg_row(qdm_pkg::REG_GAIN_MIX1, 16'h0000));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX1, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1, 0, 0));
        plan.push_back(cfg_row(qdm_pkg::REG_GAIN_MIX2, 16'd8192));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX2, -3, 3, 0, 0, 1, 1, -1, 1));
        plan.push_back(cfg_row(qdm_pkg::REG_OUTPUT_MODE, {14'd0, qdm_pkg::MODE_MONO}));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, -1, -1, -1, 0, 1, 1, -5, -5));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh8000_0000, 32'sh8000_0000, 1, 1, -32768, -32768));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                32'sh7fff_ffff, 32'sh7fff_ffff, 1));
        plan.push_back(cfg_row(qdm_pkg::REG_OUTPUT_MODE, {14'd0, MODE_UNUSED}));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 1000, 2000, -1000, 7, 1));
        plan.push_back(cfg_row(qdm_pkg::REG_OUTPUT_MODE, {14'd0, qdm_pkg::MODE_SURROUND}));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX2, -77777, 123456, 5, -9, 0));
        plan.push_back(beat_row(qdm_pkg::SEL_MIX0, 32'sh0000_ffff, -32'sd65536, 3, 3, 0));
        plan.push_back(beat_row(SEL_UNUSED, -1, -1, -1, -1, 1));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle(1);
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_beat(plan[i].beat, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    m = qdm_pkg::MODE_MONO;
                    g = '{16'hffff, 16'hffff, 16'hffff};
                end
                1:
                begin
                    m = qdm_pkg::MODE_STEREO;
                    g = '{16'h0000, qdm_pkg::GAIN_RESET, 16'hffff};
                end
                2:
                begin
                    m = qdm_pkg::MODE_SURROUND;
                    g = '{pick_gain(), pick_gain(), pick_gain()};
                end
                default:
                begin
                    m = 2'($urandom_range(0, 3));
                    g = '{pick_gain(), pick_gain(), pick_gain()};
                end
            endcase
            wait_idle(1);
            write_reg(qdm_pkg::REG_OUTPUT_MODE, {14'd0, m});
            write_reg(qdm_pkg::REG_GAIN_MIX0, g[0]);
            write_reg(qdm_pkg::REG_GAIN_MIX1, g[1]);
            write_reg(qdm_pkg::REG_GAIN_MIX2, g[2]);
            send_random(PHASE_BEATS, p == 2);
        end

        wait_idle(1);

        $display("covered %0d input beats and %0d register writes (all modes, gain extremes)",
                 beats_in, reg_writes);
        $display("%0d mixed samples compared, %0d mismatches", samples_checked, errors);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
